/* rtl/arpns_pkg.sv */
// Package for the arpeggiator note stepper: payload structs, codes, state enum
// and shared constants. No dependencies.
package arpns_pkg;

    // Default sizes
    localparam int NOTE_COUNT_DEF  = 128;
    localparam int VOICE_COUNT_DEF = 12;
    localparam int SEMITONES       = 12;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;

    // Request codes
    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_RESET = 2'd2,
        REQ_FIRE  = 2'd3
    } t_req_type;

    // Arpeggio modes
    typedef enum logic [1:0] {
        ARP_OFF    = 2'd0,
        ARP_UP     = 2'd1,
        ARP_DOWN   = 2'd2,
        ARP_UPDOWN = 2'd3
    } t_arp_mode;

    // Voice modes (code 3 means no voice action)
    localparam logic [1:0] VM_SINGLE = 2'd0;
    localparam logic [1:0] VM_PAIRS  = 2'd1;
    localparam logic [1:0] VM_UNISON = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_ARP_MODE     = 2'd0;
    localparam logic [1:0] REG_OCTAVE_RANGE = 2'd1;
    localparam logic [1:0] REG_VOICE_MODE   = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_CLEAR,
        S_FIRST,
        S_STEP,
        S_EMIT
    } t_state;

    // Input item
    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] key_note;
        logic       key_down;
    } t_req;

    // Result item
    typedef struct packed {
        logic [7:0] note;
        logic       note_on_valid;
        logic [3:0] voice_on;
        logic [3:0] voice_off;
        logic       paired;
        logic       unison;
        logic       all_off;
    } t_result;

    // Octave step: down mode counts down and reloads, others count up and wrap
    function automatic logic [1:0] step_octave(input logic [1:0] mode,
                                               input logic [1:0] oct,
                                               input logic [1:0] range);
        logic [2:0] inc;
        begin
            inc = {1'b0, oct} + 3'd1;
            if (mode == ARP_DOWN) begin
                step_octave = (oct == 2'd0) ? range : oct - 2'd1;
            end else begin
                step_octave = (inc > {1'b0, range}) ? 2'd0 : inc[1:0];
            end
        end
    endfunction

endpackage

/* rtl/arpeggiator_note_stepper_unit.sv */
// Arpeggiator note stepper: held-note map, iterative scan sequencer, voice
// assignment and APB register file. Depends on arpns_pkg.
//
// Usage:
//   Items enter on i_req when start is high and busy is low. A fire item gives
//   one result on o_result, marked by a one-cycle o_done pulse that the
//   receiver cannot hold off; other items give none. A reset-position item
//   ends at its transfer edge, a key change keeps busy high through S_KEY for
//   the map read-modify-write, and a clear keeps busy high for an S_CLEAR
//   pass that zeroes the map one entry per cycle.
//   Fire with no held note: result the next cycle; arpeggio off: the item
//   passes through S_EMIT, which registers the result. Otherwise S_FIRST
//   makes the first move, then in S_STEP one index is checked per cycle
//   through the map's single registered read port (up to NOTE_COUNT checks
//   in up and down modes, 2*NOTE_COUNT-1 in up/down), then S_EMIT forms the
//   voice assignment and registers the result. busy drops in the result
//   cycle, so the next item may be taken then. Registers arp_mode 0x0,
//   octave_range 0x4, voice_mode 0x8 are to be written only while idle; the
//   block itself does not enforce this. Reset loads register defaults, clears
//   scan state and runs the map clearing pass with busy high.
module arpeggiator_note_stepper_unit #(
    parameter int NOTE_COUNT  = arpns_pkg::NOTE_COUNT_DEF,
    parameter int VOICE_COUNT = arpns_pkg::VOICE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  arpns_pkg::t_req               i_req,
    // result channel
    output logic                          o_done,
    output arpns_pkg::t_result            o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [arpns_pkg::APB_AW-1:0]  paddr,
    input  logic [arpns_pkg::APB_DW-1:0]  pwdata,
    output logic [arpns_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import arpns_pkg::*;

    localparam int IDX_W = $clog2(NOTE_COUNT);
    localparam int CNT_W = $clog2(NOTE_COUNT + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NOTE_COUNT - 1);
    localparam logic [3:0] V_LAST = 4'(VOICE_COUNT - 1);
    localparam logic [3:0] H_LAST = 4'(VOICE_COUNT / 2 - 1);
    localparam logic [7:0] NOTE_LIMIT = 8'(NOTE_COUNT);
    localparam logic [7:0] NOTE_TOP   = 8'(NOTE_COUNT - 1 + 3 * SEMITONES);

    // Held-note map, one bit per note
    logic                r_map [NOTE_COUNT];
    logic                r_rd_bit;

    // Registers
    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_held_cnt,  n_held_cnt;
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic [1:0]          r_octave,    n_octave;
    logic                r_going_up,  n_going_up;
    logic [3:0]          r_voice_ptr, n_voice_ptr;
    logic [7:0]          r_last_note, n_last_note;
    logic [1:0]          r_arp_mode,  n_arp_mode;
    logic [1:0]          r_oct_range, n_oct_range;
    logic [1:0]          r_voice_mode, n_voice_mode;
    logic                r_done,      n_done;
    t_result             r_result,    n_result;
    logic [IDX_W-1:0]    r_clr_addr,  n_clr_addr;
    logic [IDX_W-1:0]    r_key_idx,   n_key_idx;
    logic                r_key_down,  n_key_down;

    // Scan unit outputs
    logic [IDX_W-1:0]    u_idx;
    logic [1:0]          u_octave;
    logic                u_going_up;

    logic                accept;
    logic                cfg_wr;
    logic [IDX_W-1:0]    key_idx;
    logic [7:0]          emit_note;
    logic [4:0]          v_sum;
    logic [3:0]          v_clamp;
    logic [3:0]          v_on;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic                mem_wdata;
    logic [IDX_W-1:0]    rd_addr;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign key_idx = i_req.key_note[IDX_W-1:0];
    assign o_done  = r_done;
    assign o_result = r_result;

    // Map ports: clearing pass or key write; key read while idle, scan read otherwise
    assign mem_we    = (r_state == S_CLEAR) || (r_state == S_KEY);
    assign mem_waddr = (r_state == S_KEY) ? r_key_idx : r_clr_addr;
    assign mem_wdata = (r_state == S_KEY) && r_key_down;
    assign rd_addr   = (r_state == S_IDLE) ? key_idx : u_idx;

    // Register read mux
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_ARP_MODE:     prdata[1:0] = r_arp_mode;
            REG_OCTAVE_RANGE: prdata[1:0] = r_oct_range;
            REG_VOICE_MODE:   prdata[1:0] = r_voice_mode;
            default:          prdata = '0;
        endcase
    end

    // Shared scan unit: at most one index step per cycle
    always_comb begin
        u_idx      = r_idx;
        u_octave   = r_octave;
        u_going_up = r_going_up;
        case (r_arp_mode)
            ARP_UP: begin
                if (r_idx == IDX_LAST) begin
                    u_idx    = '0;
                    u_octave = step_octave(r_arp_mode, r_octave, r_oct_range);
                end else begin
                    u_idx = r_idx + IDX_W'(1);
                end
            end
            ARP_DOWN: begin
                if (r_idx == '0) begin
                    u_idx    = IDX_LAST;
                    u_octave = step_octave(r_arp_mode, r_octave, r_oct_range);
                end else begin
                    u_idx = r_idx - IDX_W'(1);
                end
            end
            ARP_UPDOWN: begin
                if (r_state == S_FIRST) begin
                    // first move is clamped, no turn
                    if (r_going_up) begin
                        u_idx = (r_idx == IDX_LAST) ? IDX_LAST : r_idx + IDX_W'(1);
                    end else begin
                        u_idx = (r_idx == '0) ? '0 : r_idx - IDX_W'(1);
                    end
                end else if (r_going_up) begin
                    if (r_idx == IDX_LAST) begin
                        u_going_up = 1'b0;
                    end else begin
                        u_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    if (r_idx == '0) begin
                        u_going_up = 1'b1;
                        u_octave   = step_octave(r_arp_mode, r_octave, r_oct_range);
                    end else begin
                        u_idx = r_idx - IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Note and voice assignment for the emit step
    always_comb begin
        if (r_arp_mode == ARP_OFF) begin
            emit_note = r_last_note;
        end else begin
            emit_note = 8'(r_idx) + 8'(r_octave) * 8'(SEMITONES);
        end
        if (r_voice_mode == VM_PAIRS) begin
            v_clamp = (r_voice_ptr > H_LAST) ? H_LAST : r_voice_ptr;
            v_sum   = {1'b0, v_clamp} + 5'd1;
            v_on    = (v_sum > {1'b0, H_LAST}) ? 4'd0 : v_sum[3:0];
        end else begin
            v_clamp = (r_voice_ptr > V_LAST) ? V_LAST : r_voice_ptr;
            v_sum   = {1'b0, v_clamp} + 5'd1;
            v_on    = (v_sum > {1'b0, V_LAST}) ? 4'd0 : v_sum[3:0];
        end
    end

    // Sequencer: next state and register updates
    always_comb begin
        n_state      = r_state;
        n_held_cnt   = r_held_cnt;
        n_idx        = r_idx;
        n_octave     = r_octave;
        n_going_up   = r_going_up;
        n_voice_ptr  = r_voice_ptr;
        n_last_note  = r_last_note;
        n_arp_mode   = r_arp_mode;
        n_oct_range  = r_oct_range;
        n_voice_mode = r_voice_mode;
        n_done       = 1'b0;
        n_result     = r_result;
        n_clr_addr   = r_clr_addr;
        n_key_idx    = r_key_idx;
        n_key_down   = r_key_down;

        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ARP_MODE:     n_arp_mode   = pwdata[1:0];
                REG_OCTAVE_RANGE: n_oct_range  = pwdata[1:0];
                REG_VOICE_MODE:   n_voice_mode = pwdata[1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type)
                        REQ_KEY: begin
                            // old bit is read now, written back next cycle
                            if (8'(i_req.key_note) < NOTE_LIMIT) begin
                                n_state    = S_KEY;
                                n_key_idx  = key_idx;
                                n_key_down = i_req.key_down;
                            end
                        end
                        REQ_CLEAR: begin
                            n_state    = S_CLEAR;
                            n_clr_addr = '0;
                            n_held_cnt = '0;
                            n_going_up = 1'b1;
                            n_idx      = (r_arp_mode == ARP_DOWN) ? IDX_LAST : '0;
                        end
                        REQ_RESET: begin
                            n_going_up = 1'b0;
                            if (r_arp_mode == ARP_DOWN) begin
                                n_octave = r_oct_range;
                                n_idx    = IDX_LAST;
                            end else begin
                                n_octave = '0;
                                n_idx    = '0;
                            end
                        end
                        REQ_FIRE: begin
                            if (r_held_cnt == '0) begin
                                n_done           = 1'b1;
                                n_result         = '0;
                                n_result.all_off = 1'b1;
                            end else if (r_arp_mode == ARP_OFF) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_FIRST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_KEY: begin
                n_state = S_IDLE;
                if (r_key_down && !r_rd_bit) begin
                    n_held_cnt = r_held_cnt + CNT_W'(1);
                end else if (!r_key_down && r_rd_bit) begin
                    n_held_cnt = r_held_cnt - CNT_W'(1);
                end
            end
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_FIRST: begin
                n_idx      = u_idx;
                n_octave   = u_octave;
                n_going_up = u_going_up;
                n_state    = S_STEP;
            end
            S_STEP: begin
                // read data belongs to r_idx
                if (r_rd_bit) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx      = u_idx;
                    n_octave   = u_octave;
                    n_going_up = u_going_up;
                end
            end
            S_EMIT: begin
                n_state        = S_IDLE;
                n_done         = 1'b1;
                n_last_note    = emit_note;
                n_result       = '0;
                n_result.note  = emit_note;
                case (r_voice_mode)
                    VM_SINGLE, VM_PAIRS: begin
                        n_voice_ptr            = v_on;
                        n_result.note_on_valid = 1'b1;
                        n_result.voice_on      = v_on;
                        n_result.paired        = (r_voice_mode == VM_PAIRS);
                        if (v_on == 4'd0) begin
                            n_result.voice_off = (r_voice_mode == VM_PAIRS) ? H_LAST : V_LAST;
                        end else begin
                            n_result.voice_off = v_on - 4'd1;
                        end
                    end
                    VM_UNISON: begin
                        n_result.note_on_valid = (emit_note != 8'd0);
                        n_result.unison        = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and control registers; reset starts the map clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_held_cnt   <= '0;
            r_idx        <= '0;
            r_octave     <= '0;
            r_going_up   <= 1'b0;
            r_voice_ptr  <= '0;
            r_last_note  <= '0;
            r_arp_mode   <= ARP_UP;
            r_oct_range  <= 2'd0;
            r_voice_mode <= VM_SINGLE;
            r_done       <= 1'b0;
            r_clr_addr   <= '0;
            r_key_idx    <= '0;
            r_key_down   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_cnt   <= n_held_cnt;
            r_idx        <= n_idx;
            r_octave     <= n_octave;
            r_going_up   <= n_going_up;
            r_voice_ptr  <= n_voice_ptr;
            r_last_note  <= n_last_note;
            r_arp_mode   <= n_arp_mode;
            r_oct_range  <= n_oct_range;
            r_voice_mode <= n_voice_mode;
            r_done       <= n_done;
            r_clr_addr   <= n_clr_addr;
            r_key_idx    <= n_key_idx;
            r_key_down   <= n_key_down;
        end
    end

    // Note map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        r_rd_bit <= r_map[rd_addr];
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // The scan only runs while some note is held, so it always terminates
    a_scan_has_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIRST || r_state == S_STEP) |-> (r_held_cnt != '0))
        else $error("scan running with an empty note map");

    // Held count never exceeds the map size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt <= CNT_W'(NOTE_COUNT))
        else $error("held note count out of range");

    // A result follows an emit step or an empty-map fire transfer
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> ($past(r_state) == S_EMIT) ||
                          ($past(accept) && ($past(i_req.req_type) == REQ_FIRE)))
        else $error("result without a fire transfer");

    // Emitted voices and notes stay in range
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.voice_on <= V_LAST) && (o_result.voice_off <= V_LAST)
                   && (o_result.note <= NOTE_TOP))
        else $error("result field out of range");

endmodule
